// ===== rtl/lcp_pkg.sv =====
// Package for the LED command parser: command byte codes, result kinds,
// run mode numbers, the result and settings structs and the length decode.
// Depends on nothing.
package lcp_pkg;

    localparam logic [7:0] CH_FADE_FLAG = 8'h66;  // 'f'
    localparam logic [7:0] CH_FADE_MODE = 8'h46;  // 'F'
    localparam logic [7:0] CH_COLOR     = 8'h63;  // 'c'
    localparam logic [7:0] CH_COLOR2    = 8'h78;  // 'x'
    localparam logic [7:0] CH_REPEAT    = 8'h52;  // 'R'
    localparam logic [7:0] CH_BRIGHT    = 8'h62;  // 'b'
    localparam logic [7:0] CH_PIXEL     = 8'h31;  // '1'
    localparam logic [7:0] CH_RAW       = 8'h72;  // 'r'
    localparam logic [7:0] CH_MCOLOR    = 8'h43;  // 'C'
    localparam logic [7:0] CH_TWINKLE   = 8'h54;  // 'T'
    localparam logic [7:0] CH_WIPE      = 8'h57;  // 'W'
    localparam logic [7:0] CH_PULSE     = 8'h70;  // 'p'
    localparam logic [7:0] CH_TARDIS    = 8'h74;  // 't'
    localparam logic [7:0] CH_CHASE     = 8'h21;  // '!'

    localparam logic [3:0] KIND_FADE_FLAG = 4'd0;
    localparam logic [3:0] KIND_FADE_MODE = 4'd1;
    localparam logic [3:0] KIND_COLOR     = 4'd2;
    localparam logic [3:0] KIND_COLOR2    = 4'd3;
    localparam logic [3:0] KIND_REPEAT    = 4'd4;
    localparam logic [3:0] KIND_MODE      = 4'd5;
    localparam logic [3:0] KIND_PIX_FADE  = 4'd6;
    localparam logic [3:0] KIND_PIX_SET   = 4'd7;
    localparam logic [3:0] KIND_BRIGHT    = 4'd8;
    localparam logic [3:0] KIND_IGNORED   = 4'd9;

    localparam logic [2:0] MODE_RAW     = 3'd1;
    localparam logic [2:0] MODE_COLOR   = 3'd2;
    localparam logic [2:0] MODE_TWINKLE = 3'd3;
    localparam logic [2:0] MODE_WIPE    = 3'd4;
    localparam logic [2:0] MODE_PULSE   = 3'd5;
    localparam logic [2:0] MODE_TARDIS  = 3'd6;
    localparam logic [2:0] MODE_CHASE   = 3'd7;

    localparam logic [1:0] CFG_INITIAL_MODE   = 2'd0;
    localparam logic [1:0] CFG_INITIAL_COLOR  = 2'd1;
    localparam logic [1:0] CFG_INITIAL_COLOR2 = 2'd2;

    localparam logic [2:0]  RESET_MODE  = MODE_RAW;
    localparam logic [23:0] RESET_COLOR = 24'hFFFFFF;
    localparam logic [2:0]  LAST_SLOT   = 3'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] pixel_index;
        logic [23:0] pixel_color;
        logic [2:0]  new_mode;
        logic        fader_reset;
        logic        fade_direction;
        logic [7:0]  arg_value;
        logic        lights_changed;
    } t_result;

    typedef struct packed {
        logic        fade_enable;
        logic        fade_inv_nz;
        logic [23:0] color;
        logic [2:0]  mode;
    } t_state;

    function automatic logic [2:0] needed_bytes(input logic [7:0] first);
        logic [2:0] n;
        case (first)
            CH_FADE_FLAG, CH_FADE_MODE, CH_REPEAT, CH_BRIGHT: n = 3'd2;
            CH_PIXEL:                                          n = 3'd3;
            CH_COLOR, CH_COLOR2:                               n = 3'd4;
            default:                                           n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/lcp_exec.sv =====
// Command decode and execute for the LED command parser: merges the new byte
// into the buffered command, detects completion and runs the command.
// Depends on lcp_pkg.
module lcp_exec
    import lcp_pkg::*;
(
    input  logic [7:0]      i_cmd_byte,
    input  logic [2:0]      i_count,
    input  logic [3:0][7:0] i_buf,
    input  t_state          i_state,
    output logic            o_fire,
    output logic [2:0]      o_count,
    output t_state          o_state,
    output t_result         o_result
);

    always_comb begin
        logic [3:0][7:0] b;
        logic [2:0]      cnt_inc;
        logic            mode_hit;
        logic [2:0]      mode_val;
        for (int i = 0; i < 4; i++) begin
            b[i] = (i_count[1:0] == 2'(i)) ? i_cmd_byte : i_buf[i];
        end
        cnt_inc  = i_count + 3'd1;
        o_fire   = (cnt_inc == needed_bytes(b[0]));
        o_state  = i_state;
        o_result = '0;
        o_result.kind = KIND_IGNORED;
        mode_hit = 1'b0;
        mode_val = '0;
        if (o_fire) begin
            o_count = '0;
        end else if (cnt_inc > LAST_SLOT) begin
            o_count = '0;
        end else begin
            o_count = cnt_inc;
        end
        if (o_fire) begin
            unique case (b[0])
                CH_FADE_FLAG: begin
                    o_state.fade_enable = (b[1] != 8'd0);
                    o_result.kind       = KIND_FADE_FLAG;
                    o_result.arg_value  = b[1];
                end
                CH_FADE_MODE: begin
                    o_state.fade_inv_nz = (b[1] != 8'd0);
                    o_result.kind       = KIND_FADE_MODE;
                    o_result.arg_value  = b[1];
                end
                CH_COLOR: begin
                    o_state.color        = {b[1], b[2], b[3]};
                    o_result.kind        = KIND_COLOR;
                    o_result.pixel_color = {b[1], b[2], b[3]};
                end
                CH_COLOR2: begin
                    o_result.kind        = KIND_COLOR2;
                    o_result.pixel_color = {b[1], b[2], b[3]};
                end
                CH_REPEAT: begin
                    o_result.kind      = KIND_REPEAT;
                    o_result.arg_value = b[1];
                end
                CH_BRIGHT: begin
                    o_result.kind           = KIND_BRIGHT;
                    o_result.arg_value      = b[1];
                    o_result.lights_changed = 1'b1;
                end
                CH_PIXEL: begin
                    if (i_state.mode == MODE_RAW) begin
                        o_result.kind = i_state.fade_enable ? KIND_PIX_FADE : KIND_PIX_SET;
                        o_result.pixel_index    = {b[1], b[2]};
                        o_result.pixel_color    = i_state.color;
                        o_result.lights_changed = 1'b1;
                    end
                end
                CH_RAW: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_RAW;
                end
                CH_MCOLOR: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_COLOR;
                end
                CH_TWINKLE: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_TWINKLE;
                end
                CH_WIPE: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_WIPE;
                end
                CH_PULSE: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_PULSE;
                end
                CH_TARDIS: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_TARDIS;
                end
                CH_CHASE: begin
                    mode_hit = 1'b1;
                    mode_val = MODE_CHASE;
                end
                default: begin
                    mode_hit = 1'b0;
                end
            endcase
            if (mode_hit) begin
                o_state.mode      = mode_val;
                o_result.kind     = KIND_MODE;
                o_result.new_mode = mode_val;
                if (mode_val != MODE_RAW && mode_val != MODE_PULSE) begin
                    o_result.fader_reset    = 1'b1;
                    o_result.fade_direction = (mode_val == MODE_WIPE) ^ i_state.fade_inv_nz;
                end
            end
        end
    end

endmodule

// ===== rtl/led_command_parser_core.sv =====
// LED command parser core: one command byte per transfer, executes complete
// commands and emits one result per command. Depends on lcp_pkg and lcp_exec.
// A result is registered in the output stage when the command's last byte is transferred.
// Throughput: one byte per cycle while the skid entry is empty; a two-entry output stage absorbs output stalls.
// Reset (synchronous, active low) empties the buffer and output stage and loads the reset settings.
module led_command_parser_core
    import lcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_cmd_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [15:0] o_pixel_index,
    output logic [23:0] o_pixel_color,
    output logic [2:0]  o_new_mode,
    output logic        o_fader_reset,
    output logic        o_fade_direction,
    output logic [7:0]  o_arg_value,
    output logic        o_lights_changed
);

    logic [3:0][7:0] r_buf;
    logic [2:0]      r_count;
    t_state          r_state;
    t_result         r_out;
    t_result         r_skid;
    logic            r_out_valid;
    logic            r_skid_valid;

    logic            fire;
    logic [2:0]      n_count;
    t_state          n_state;
    t_state          n_settings;
    t_result         res;
    logic            accept;
    logic            pop;

    lcp_exec u_exec (
        .i_cmd_byte (i_cmd_byte),
        .i_count    (r_count),
        .i_buf      (r_buf),
        .i_state    (r_state),
        .o_fire     (fire),
        .o_count    (n_count),
        .o_state    (n_state),
        .o_result   (res)
    );

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;

    always_comb begin
        n_settings = accept ? n_state : r_state;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INITIAL_MODE:  n_settings.mode  = i_cfg_data[2:0];
                CFG_INITIAL_COLOR: n_settings.color = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_count[1:0]] <= i_cmd_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count             <= '0;
            r_state.fade_enable <= 1'b1;
            r_state.fade_inv_nz <= 1'b0;
            r_state.color       <= RESET_COLOR;
            r_state.mode        <= RESET_MODE;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            r_state <= n_settings;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (pop || !r_out_valid) begin
            r_out_valid <= accept && fire;
            r_out       <= res;
        end else if (accept && fire) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_pixel_index    = r_out.pixel_index;
    assign o_pixel_color    = r_out.pixel_color;
    assign o_new_mode       = r_out.new_mode;
    assign o_fader_reset    = r_out.fader_reset;
    assign o_fade_direction = r_out.fade_direction;
    assign o_arg_value      = r_out.arg_value;
    assign o_lights_changed = r_out.lights_changed;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register is empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_SLOT)
        else $error("byte count beyond command buffer");

    a_pixel_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_PIX_FADE || o_kind == KIND_PIX_SET))
            |-> o_lights_changed)
        else $error("pixel result without lights change");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_kind)))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/lcp_command_checker.sv =====
// Result checker for the LED command parser core. It watches the byte, preset
// and result channels, predicts every result from its own copy of the settings
// and compares field by field. Depends on lcp_pkg.
module lcp_command_checker
    import lcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_cmd_byte,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_result,
    output int          o_mismatches,
    output int          o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  cmd_buf [4];
    logic [2:0]  byte_cnt;
    logic        fade_en;
    logic [7:0]  fade_inv;
    logic [23:0] color_pri;
    logic [23:0] color_sec;
    logic [8:0]  repeat_cnt;
    logic [2:0]  run_mode;
    t_result     owed_q [$];

    initial o_mismatches = 0;
    initial o_results_owed = 0;

    function automatic logic [2:0] command_length(input logic [7:0] first);
        case (first)
            CH_FADE_FLAG, CH_FADE_MODE, CH_REPEAT, CH_BRIGHT: return 3'd2;
            CH_PIXEL:                                          return 3'd3;
            CH_COLOR, CH_COLOR2:                               return 3'd4;
            default:                                           return 3'd1;
        endcase
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        t_result     r;
        logic [2:0]  m;
        logic        is_mode;
        logic [23:0] rgb;
        cmd_buf[byte_cnt[1:0]] = b;
        byte_cnt = byte_cnt + 3'd1;
        if (byte_cnt == command_length(cmd_buf[0])) begin
            r = '0;
            r.kind = KIND_IGNORED;
            m = '0;
            is_mode = 1'b0;
            rgb = {cmd_buf[1], cmd_buf[2], cmd_buf[3]};
            case (cmd_buf[0])
                CH_FADE_FLAG: begin
                    fade_en = |cmd_buf[1];
                    r.kind = KIND_FADE_FLAG;
                    r.arg_value = cmd_buf[1];
                end
                CH_FADE_MODE: begin
                    fade_inv = cmd_buf[1];
                    r.kind = KIND_FADE_MODE;
                    r.arg_value = cmd_buf[1];
                end
                CH_COLOR: begin
                    color_pri = rgb;
                    r.kind = KIND_COLOR;
                    r.pixel_color = rgb;
                end
                CH_COLOR2: begin
                    color_sec = rgb;
                    r.kind = KIND_COLOR2;
                    r.pixel_color = rgb;
                end
                CH_REPEAT: begin
                    repeat_cnt = {1'b0, cmd_buf[1]};
                    r.kind = KIND_REPEAT;
                    r.arg_value = cmd_buf[1];
                end
                CH_BRIGHT: begin
                    r.kind = KIND_BRIGHT;
                    r.arg_value = cmd_buf[1];
                    r.lights_changed = 1'b1;
                end
                CH_PIXEL: begin
                    if (run_mode == MODE_RAW) begin
                        r.kind = fade_en ? KIND_PIX_FADE : KIND_PIX_SET;
                        r.pixel_index = {cmd_buf[1], cmd_buf[2]};
                        r.pixel_color = color_pri;
                        r.lights_changed = 1'b1;
                    end
                end
                CH_RAW:     begin m = MODE_RAW;     is_mode = 1'b1; end
                CH_MCOLOR:  begin m = MODE_COLOR;   is_mode = 1'b1; end
                CH_TWINKLE: begin m = MODE_TWINKLE; is_mode = 1'b1; end
                CH_WIPE:    begin m = MODE_WIPE;    is_mode = 1'b1; end
                CH_PULSE:   begin m = MODE_PULSE;   is_mode = 1'b1; end
                CH_TARDIS:  begin m = MODE_TARDIS;  is_mode = 1'b1; end
                CH_CHASE:   begin m = MODE_CHASE;   is_mode = 1'b1; end
                default: ;
            endcase
            if (is_mode) begin
                run_mode = m;
                r.kind = KIND_MODE;
                r.new_mode = m;
                if (m != MODE_RAW && m != MODE_PULSE) begin
                    r.fader_reset = 1'b1;
                    r.fade_direction = (m == MODE_WIPE) ^ (fade_inv != 8'd0);
                end
            end
            owed_q.push_back(r);
            byte_cnt = '0;
        end
        if (byte_cnt > LAST_SLOT)
            byte_cnt = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s is %0h, predicted %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (owed_q.size() == 0) begin
            report_mismatch("kind of a result with none owed", 32'(got.kind), 0);
            return;
        end
        want = owed_q.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", 32'(got.pixel_index), 32'(want.pixel_index));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", 32'(got.pixel_color), 32'(want.pixel_color));
        if (got.new_mode !== want.new_mode)
            report_mismatch("new_mode", 32'(got.new_mode), 32'(want.new_mode));
        if (got.fader_reset !== want.fader_reset)
            report_mismatch("fader_reset", 32'(got.fader_reset), 32'(want.fader_reset));
        if (got.fade_direction !== want.fade_direction)
            report_mismatch("fade_direction", 32'(got.fade_direction),
                            32'(want.fade_direction));
        if (got.arg_value !== want.arg_value)
            report_mismatch("arg_value", 32'(got.arg_value), 32'(want.arg_value));
        if (got.lights_changed !== want.lights_changed)
            report_mismatch("lights_changed", 32'(got.lights_changed),
                            32'(want.lights_changed));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (cmd_buf[k])
                cmd_buf[k] = '0;
            byte_cnt = '0;
            fade_en = 1'b1;
            fade_inv = '0;
            color_pri = RESET_COLOR;
            color_sec = '0;
            repeat_cnt = '1;
            run_mode = RESET_MODE;
            owed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INITIAL_MODE:   run_mode = i_cfg_data[2:0];
                    CFG_INITIAL_COLOR:  color_pri = i_cfg_data;
                    CFG_INITIAL_COLOR2: color_sec = i_cfg_data;
                    default: ;
                endcase
            end
            // A result can never belong to a byte taken at this same edge.
            if (i_out_valid && i_out_ready)
                check_result(i_result);
            if (i_in_valid && i_in_ready)
                decode_byte(i_cmd_byte);
        end
        o_results_owed = owed_q.size();
    end

endmodule

// ===== tb/sv/tb_led_command_parser_core.sv =====
// Top of the LED command parser testbench: clock, reset, command byte and preset
// stimulus with random idling, random output back-pressure, a watchdog and the final verdict.
// Depends on lcp_pkg, led_command_parser_core and lcp_command_checker.
module tb_led_command_parser_core
    import lcp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_INVALID = 3'd0;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 350;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  cmd_byte = '0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        cfg_ready;
    logic        out_valid;
    logic [3:0]  kind;
    logic [15:0] pixel_index;
    logic [23:0] pixel_color;
    logic [2:0]  new_mode;
    logic        fader_reset;
    logic        fade_direction;
    logic [7:0]  arg_value;
    logic        lights_changed;
    int          mismatches;
    int          results_owed;
    int          results_seen = 0;
    int          sent_bytes = 0;
    int          burst_left = 0;

    logic [7:0] opening_seq [0:32] = '{
        CH_PIXEL, 8'h00, 8'h00,
        CH_FADE_FLAG, 8'h00,
        CH_COLOR, 8'h00, 8'h00, 8'h00,
        CH_PIXEL, 8'hFF, 8'hFF,
        CH_COLOR2, 8'hFF, 8'hFF, 8'hFF,
        CH_FADE_MODE, 8'hFF,
        CH_WIPE,
        CH_PIXEL, 8'h12, 8'h34,
        CH_TWINKLE, CH_PULSE, CH_TARDIS, CH_CHASE, CH_MCOLOR,
        CH_REPEAT, 8'h00,
        CH_BRIGHT, 8'hFF,
        8'hFF,
        CH_RAW
    };

    led_command_parser_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_cmd_byte      (cmd_byte),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (kind),
        .o_pixel_index   (pixel_index),
        .o_pixel_color   (pixel_color),
        .o_new_mode      (new_mode),
        .o_fader_reset   (fader_reset),
        .o_fade_direction(fade_direction),
        .o_arg_value     (arg_value),
        .o_lights_changed(lights_changed)
    );

    lcp_command_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_cmd_byte    (cmd_byte),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_result      ({kind, pixel_index, pixel_color, new_mode, fader_reset,
                         fade_direction, arg_value, lights_changed}),
        .o_mismatches  (mismatches),
        .o_results_owed(results_owed)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (out_valid && out_ready)
            results_seen <= results_seen + 1;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd_byte <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_bytes++;
    endtask

    function automatic logic [7:0] pick_arg();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_command();
        int          sel;
        int          n_args;
        logic [7:0]  op;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (sel < 33) begin
            send_byte(CH_PIXEL);
            send_byte(pick_arg());
            send_byte(pick_arg());
        end else if (sel < 50) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = CH_RAW;
                4:          op = CH_MCOLOR;
                5:          op = CH_TWINKLE;
                6:          op = CH_WIPE;
                7:          op = CH_PULSE;
                8:          op = CH_TARDIS;
                default:    op = CH_CHASE;
            endcase
            send_byte(op);
        end else begin
            case ($urandom_range(0, 5))
                0:       op = CH_FADE_FLAG;
                1:       op = CH_FADE_MODE;
                2:       op = CH_COLOR;
                3:       op = CH_COLOR2;
                4:       op = CH_REPEAT;
                default: op = CH_BRIGHT;
            endcase
            n_args = (op == CH_COLOR || op == CH_COLOR2) ? 3 : 1;
            send_byte(op);
            repeat (n_args) send_byte(pick_arg());
        end
    endtask

    // Waits until every owed result has arrived, then lets a possible partial
    // command settle before the presets change.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_preset(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    initial begin : out_sink
        int pattern;
        int pattern_left;
        int hold_left;
        int hold_at;
        pattern = 0;
        pattern_left = 0;
        hold_left = 0;
        hold_at = 100;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && hold_at <= 500 && results_seen >= hold_at) begin
                hold_left = 300;
                hold_at += 400;
            end
            if (pattern_left == 0) begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (pattern)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (pattern_left % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_led_command_parser_core NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [2:0]  mode;
        logic [23:0] col;
        logic [23:0] col2;
        int          target;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_seq[k])
            send_byte(opening_seq[k]);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    mode = MODE_INVALID;
                    col = 24'h000000;
                    col2 = 24'hFFFFFF;
                end
                1: begin
                    mode = MODE_CHASE;
                    col = 24'hFFFFFF;
                    col2 = 24'h000000;
                end
                2: begin
                    mode = MODE_RAW;
                    col = 24'($urandom);
                    col2 = 24'($urandom);
                end
                default: begin
                    mode = 3'($urandom_range(0, 7));
                    col = 24'($urandom);
                    col2 = 24'($urandom);
                end
            endcase
            drain();
            write_preset(CFG_INITIAL_MODE, {21'd0, mode});
            write_preset(CFG_INITIAL_COLOR, col);
            write_preset(CFG_INITIAL_COLOR2, col2);
            cfg_valid <= 1'b0;
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target)
                send_command();
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("tb_led_command_parser_core OK");
        else
            $display("tb_led_command_parser_core NOT OK");
        $finish;
    end

endmodule

// ===== led_command_parser_core.f =====
rtl/lcp_pkg.sv
rtl/lcp_exec.sv
rtl/led_command_parser_core.sv
tb/sv/lcp_command_checker.sv
tb/sv/tb_led_command_parser_core.sv
